// ----- rtl/core/q15sr_pkg.sv -----
package q15sr_pkg;

   // Field widths
   localparam int RADICAND_WIDTH = 32;
   localparam int ROOT_WIDTH     = 24;

   // Digit-serial root engine: one result bit per bit pair of the operand
   localparam int ENGINE_ROOT_WIDTH = RADICAND_WIDTH / 2;
   localparam int ENGINE_REM_WIDTH  = ENGINE_ROOT_WIDTH + 1;
   localparam int ENGINE_STEPS      = RADICAND_WIDTH / 2;
   localparam int STEP_COUNT_WIDTH  = $clog2(ENGINE_STEPS);

   // Prescale step count: at most eight divide-by-four steps
   localparam int SCALE_COUNT_WIDTH = 4;

   typedef logic signed [RADICAND_WIDTH-1:0] radicand_type;
   typedef logic [RADICAND_WIDTH-1:0]        operand_type;
   typedef logic [ROOT_WIDTH-1:0]            root_type;
   typedef logic [ENGINE_ROOT_WIDTH-1:0]     engine_root_type;
   typedef logic [SCALE_COUNT_WIDTH-1:0]     scale_count_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ROOT,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/core/q15sr_if.sv -----
// Request channel: one radicand per transaction
interface q15sr_req_if;
   logic                   valid;
   logic                   ready;
   q15sr_pkg::radicand_type radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

// Response channel: one root per transaction
interface q15sr_rsp_if;
   logic               valid;
   logic               ready;
   q15sr_pkg::root_type root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

// ----- rtl/core/q15sr_prescale.sv -----
// Iterative prescaler: divides by four with rounding, one step per cycle,
// until the value is no larger than the limit; counts the steps taken.
module q15sr_prescale #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  q15sr_pkg::operand_type     value,
   output logic                       done,
   output q15sr_pkg::operand_type     scaled,
   output q15sr_pkg::scale_count_type count
);

   localparam q15sr_pkg::operand_type Limit =
      q15sr_pkg::operand_type'(32'hFFFF_FFFF >> FRACTION_BITS);

   logic                       busy_ff, busy_in;
   q15sr_pkg::operand_type     scaled_ff, scaled_in;
   q15sr_pkg::scale_count_type count_ff, count_in;
   logic                       over;

   assign over = scaled_ff > Limit;

   // Load, step or finish
   always_comb begin
      busy_in   = busy_ff;
      scaled_in = scaled_ff;
      count_in  = count_ff;
      if (start) begin
         busy_in   = 1'b1;
         scaled_in = value;
         count_in  = '0;
      end else if (busy_ff) begin
         if (over) begin
            scaled_in = (scaled_ff + q15sr_pkg::operand_type'(2)) >> 2;
            count_in  = count_ff + q15sr_pkg::scale_count_type'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      scaled_ff <= scaled_in;
      count_ff  <= count_in;
   end

   assign done   = busy_ff & ~over;
   assign scaled = scaled_ff;
   assign count  = count_ff;

endmodule

// ----- rtl/core/q15sr_root.sv -----
// Digit-serial restoring square root: the operand shifts out two bits per
// cycle, the root grows by one bit per cycle.
module q15sr_root (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  q15sr_pkg::operand_type      value,
   output logic                        done,
   output q15sr_pkg::engine_root_type  root
);

   localparam int RemWidth   = q15sr_pkg::ENGINE_REM_WIDTH;
   localparam int RootWidth  = q15sr_pkg::ENGINE_ROOT_WIDTH;
   localparam int CountWidth = q15sr_pkg::STEP_COUNT_WIDTH;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CountWidth-1:0]            count_ff, count_in;
   q15sr_pkg::operand_type           operand_ff, operand_in;
   logic [RemWidth-1:0]              rem_ff, rem_in;
   q15sr_pkg::engine_root_type       root_ff, root_in;
   logic [RemWidth+1:0]              rem_shift;
   logic [RemWidth+1:0]              trial;
   logic                             fits;

   // One bit pair: bring in two operand bits, try root*4+1
   assign rem_shift = {rem_ff, operand_ff[q15sr_pkg::RADICAND_WIDTH-1 -: 2]};
   assign trial     = (RemWidth + 2)'({root_ff, 2'b01});
   assign fits      = rem_shift >= trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      operand_in = operand_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         operand_in = value;
         rem_in     = '0;
         root_in    = '0;
      end else if (busy_ff) begin
         operand_in = operand_ff << 2;
         if (fits) begin
            rem_in  = RemWidth'(rem_shift - trial);
            root_in = {root_ff[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = RemWidth'(rem_shift);
            root_in = {root_ff[RootWidth-2:0], 1'b0};
         end
         count_in = count_ff + CountWidth'(1);
         if (count_ff == CountWidth'(q15sr_pkg::ENGINE_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      operand_ff <= operand_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/core/q15_square_root.sv -----
// Channel   Port    Dir  Payload
// request   req_if  in   radicand : signed 32-bit fixed point
// response  rsp_if  out  root     : unsigned 24-bit fixed point
//
// One transaction at a time. A positive radicand goes from acceptance
// through k prescale steps, where k (0 to 8) is the number of prescale
// steps, then the bit-pair root engine, to a valid response. A zero or
// negative radicand skips both units and goes to the response register.
// Synchronous active-high reset returns the sequencer to idle and empties
// the response register. A new request is taken while a response waits;
// a finished root waits in the engine while the response stalls.
module q15_square_root #(
   parameter int FRACTION_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   q15sr_req_if.sink          req_if,
   q15sr_rsp_if.source        rsp_if
);

   q15sr_pkg::state_type       state_ff, state_in;
   logic                       zero_ff, zero_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   q15sr_pkg::root_type        rsp_root_ff, rsp_root_in;

   logic                       accept;
   logic                       nonpositive;
   logic                       scale_start;
   logic                       scale_done;
   q15sr_pkg::operand_type     scaled;
   q15sr_pkg::scale_count_type scale_count;
   logic                       root_start;
   logic                       root_done;
   q15sr_pkg::engine_root_type engine_root;
   q15sr_pkg::operand_type     root_operand;
   q15sr_pkg::root_type        final_root;
   logic                       out_free;
   logic                       out_load;

   assign accept      = req_if.valid & req_if.ready;
   assign nonpositive = req_if.radicand[q15sr_pkg::RADICAND_WIDTH-1] |
                        (req_if.radicand == '0);
   assign out_free    = ~rsp_valid_ff | rsp_if.ready;

   // Units
   q15sr_prescale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_prescale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .value  (q15sr_pkg::operand_type'(req_if.radicand)),
      .done   (scale_done),
      .scaled (scaled),
      .count  (scale_count)
   );

   assign root_operand = scaled << FRACTION_BITS;

   q15sr_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (root_operand),
      .done  (root_done),
      .root  (engine_root)
   );

   // Undo the prescale: multiply by 2^k
   assign final_root = q15sr_pkg::root_type'(engine_root) << scale_count;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         q15sr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = nonpositive ? q15sr_pkg::ST_FINISH : q15sr_pkg::ST_SCALE;
            end
         end
         q15sr_pkg::ST_SCALE: begin
            if (scale_done) begin
               state_in = q15sr_pkg::ST_ROOT;
            end
         end
         q15sr_pkg::ST_ROOT: begin
            if (root_done) begin
               state_in = q15sr_pkg::ST_FINISH;
            end
         end
         q15sr_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = q15sr_pkg::ST_IDLE;
            end
         end
         default: state_in = q15sr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_if.ready = 1'b0;
      scale_start  = 1'b0;
      root_start   = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         q15sr_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            scale_start  = req_if.valid & ~nonpositive;
         end
         q15sr_pkg::ST_SCALE: begin
            root_start = scale_done;
         end
         q15sr_pkg::ST_ROOT: begin
         end
         q15sr_pkg::ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Zero flag and response register
   always_comb begin
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_root_in  = rsp_root_ff;
      if (accept) begin
         zero_in = nonpositive;
      end
      if (rsp_valid_ff & rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_root_in  = zero_ff ? '0 : final_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= q15sr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zero_ff     <= zero_in;
      rsp_root_ff <= rsp_root_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.root  = rsp_root_ff;

endmodule
